@@ src/mpss_pkg.sv @@
`timescale 1ns / 1ps

package mpss_pkg;

  // sizes and limits
  localparam int unsigned PIXEL_COUNT_DEF = 65536;
  localparam int unsigned MAX_IMAGES      = 1024;
  localparam int unsigned SAMPLE_BITS     = 8;

  localparam int unsigned IDX_W    = 16;
  localparam int unsigned SMP_W    = 8;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned DEV_W    = 20;
  localparam int unsigned SQ_W     = 26;
  localparam int unsigned VAR_W    = 18;
  localparam int unsigned QUO_W    = 18;
  localparam int unsigned MDEN_W   = 11;
  localparam int unsigned VDEN_W   = 21;
  localparam int unsigned SUM_W    = 18;
  localparam int unsigned DIFF_W   = 38;
  localparam int unsigned VNUM_W   = 42;
  localparam int unsigned CFG_AW   = 4;
  localparam int unsigned CFG_DW   = 32;

  localparam logic [SMP_W-1:0] SAMPLE_MASK = SMP_W'((1 << SAMPLE_BITS) - 1);
  localparam logic [CNT_W-1:0] CNT_FULL    = CNT_W'(MAX_IMAGES);

  // register indexes
  localparam logic [1:0] REG_MEAN_VAR = 2'd0;
  localparam logic [1:0] REG_MINIMUM  = 2'd1;
  localparam logic [1:0] REG_MAXIMUM  = 2'd2;

  // one row of the per-pixel store
  typedef struct packed {
    logic                    known;
    logic [SMP_W-1:0]        refv;
    logic [CNT_W-1:0]        cnt;
    logic signed [DEV_W-1:0] dev;
    logic [SQ_W-1:0]         sq;
    logic [SMP_W-1:0]        mn;
    logic [SMP_W-1:0]        mx;
  } row_t;

  localparam row_t ROW_RESET = '{
    known: 1'b0, refv: '0, cnt: '0, dev: '0, sq: '0, mn: SAMPLE_MASK, mx: '0
  };

  // operands of the two division lanes
  typedef struct packed {
    logic [MDEN_W-1:0] mden;
    logic [MDEN_W-1:0] mrem;
    logic [QUO_W-1:0]  mlo;
    logic [VDEN_W-1:0] vden;
    logic [VDEN_W-1:0] vrem;
    logic [QUO_W-1:0]  vlo;
  } div_in_t;

  typedef struct packed {
    logic [QUO_W-1:0]  mquo;
    logic [MDEN_W-1:0] mrem;
    logic [QUO_W-1:0]  vquo;
  } div_out_t;

  // sideband that rides along the divider
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] n;
    logic [SMP_W-1:0] mn;
    logic [SMP_W-1:0] mx;
    logic             sat;
    logic             vsat;
  } side_t;

  localparam int unsigned SIDE_W = $bits(side_t);

endpackage

@@ src/masked_pixel_stack_statistics.sv @@
`timescale 1ns / 1ps
// throughput: one transaction per cycle while out_tready does not stall the pipe;
//   a read-modify-write of the pixel store with forwarding and an 18-stage
//   two-lane divider keep that rate
// reset: rst_n synchronous, active low; registers return to enabled and a
//   clearing pass then writes every row of the store, during which no input
//   transaction is taken (config writes still are)

module masked_pixel_stack_statistics
  import mpss_pkg::*;
#(
  parameter int unsigned PIXEL_COUNT = PIXEL_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // pixel_index[15:0], sample[23:16]
  input  logic              in_tuser,   // include_req
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [71:0]       out_tdata,  // out_index[15:0], mean_value[23:16],
                                        // variance_value[41:24], minimum_value[49:42],
                                        // maximum_value[57:50], sample_count[68:58],
                                        // count_saturated[69], zero[71:70]
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int unsigned AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(PIXEL_COUNT - 1);

  // ---------------- configuration ----------------
  logic en_mv_r, en_mn_r, en_mx_r;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_mv_r <= 1'b1;
      en_mn_r <= 1'b1;
      en_mx_r <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_MEAN_VAR: en_mv_r <= cfg_pwdata[0];
        REG_MINIMUM:  en_mn_r <= cfg_pwdata[0];
        REG_MAXIMUM:  en_mx_r <= cfg_pwdata[0];
        default: ;  // no register here, write dropped
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (cfg_paddr[3:2])
      REG_MEAN_VAR: cfg_prdata[0] = en_mv_r;
      REG_MINIMUM:  cfg_prdata[0] = en_mn_r;
      REG_MAXIMUM:  cfg_prdata[0] = en_mx_r;
      default:      cfg_prdata    = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // every stage moves together; the output register frees the pipe
  logic out_valid_r;
  logic advance;
  logic clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance && !clr_busy_r;

  // clearing pass after reset, one row per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == LAST_ADDR) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // ---------------- stage 1: input register ----------------
  logic             s1_valid_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic [SMP_W-1:0] s1_smp_r;
  logic             s1_inc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_tvalid && in_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_idx_r <= in_tdata[15:0];
      s1_smp_r <= in_tdata[23:16] & SAMPLE_MASK;
      s1_inc_r <= in_tuser;
    end
  end

  // ---------------- pixel store ----------------
  row_t          mem [PIXEL_COUNT];
  row_t          rd_row_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  row_t          mem_wdata;
  logic [AW-1:0] s1_addr;

  // stage 2 signals used by the write port
  logic             s2_valid_r;
  logic [IDX_W-1:0] s2_idx_r;
  logic [SMP_W-1:0] s2_smp_r;
  logic             s2_inc_r;
  logic             s2_inr_r;
  logic             s2_wr;
  row_t             s2_new;

  assign s1_addr = AW'(s1_idx_r);

  always_comb begin
    if (clr_busy_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = ROW_RESET;
    end else begin
      mem_we    = s2_wr;
      mem_waddr = AW'(s2_idx_r);
      mem_wdata = s2_new;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (advance) begin
      rd_row_r <= mem[s1_addr];
    end
  end

  // ---------------- stage 2: update the row ----------------
  // a row written in the cycle it is read comes through the bypass
  logic fwd_hit_r;
  row_t fwd_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
      fwd_hit_r  <= s2_wr && s1_valid_r && (s2_idx_r == s1_idx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_idx_r  <= s1_idx_r;
      s2_smp_r  <= s1_smp_r;
      s2_inc_r  <= s1_inc_r;
      s2_inr_r  <= 32'(s1_idx_r) < PIXEL_COUNT;
      fwd_row_r <= s2_new;
    end
  end

  row_t                    cur;
  logic                    upd, sat;
  logic [SMP_W-1:0]        refv_use;
  logic signed [SMP_W:0]   dlt;
  logic [SMP_W-1:0]        dmag;
  logic [2*SMP_W-1:0]      dsq;
  logic [CNT_W-1:0]        rep_n;
  logic signed [DEV_W-1:0] rep_dev;
  logic [SQ_W-1:0]         rep_sq;
  logic [SMP_W-1:0]        rep_ref, rep_mn, rep_mx;

  always_comb begin
    cur      = fwd_hit_r ? fwd_row_r : rd_row_r;
    sat      = s2_inr_r && en_mv_r && s2_inc_r && (cur.cnt >= CNT_FULL);
    upd      = s2_inr_r && en_mv_r && s2_inc_r && !sat;
    refv_use = cur.known ? cur.refv : s2_smp_r;
    dlt      = $signed({1'b0, s2_smp_r}) - $signed({1'b0, refv_use});
    dmag     = dlt[SMP_W] ? SMP_W'(-dlt) : dlt[SMP_W-1:0];
    dsq      = (2*SMP_W)'(dmag) * (2*SMP_W)'(dmag);
    s2_new   = cur;
    if (upd) begin
      s2_new.known = 1'b1;
      s2_new.refv  = refv_use;
      s2_new.cnt   = cur.cnt + 1'b1;
      s2_new.dev   = cur.dev + DEV_W'(dlt);
      s2_new.sq    = cur.sq + SQ_W'(dsq);
    end
    if (en_mn_r && s2_inc_r && (s2_smp_r < cur.mn)) begin
      s2_new.mn = s2_smp_r;
    end
    if (en_mx_r && s2_inc_r && (s2_smp_r > cur.mx)) begin
      s2_new.mx = s2_smp_r;
    end
    s2_wr = s2_valid_r && s2_inr_r && advance && !clr_busy_r;
    // an index past the store reports an empty pixel
    if (s2_inr_r) begin
      rep_n   = s2_new.cnt;
      rep_dev = s2_new.dev;
      rep_sq  = s2_new.sq;
      rep_ref = s2_new.known ? s2_new.refv : '0;
      rep_mn  = s2_new.mn;
      rep_mx  = s2_new.mx;
    end else begin
      rep_n   = '0;
      rep_dev = '0;
      rep_sq  = '0;
      rep_ref = '0;
      rep_mn  = SAMPLE_MASK;
      rep_mx  = '0;
    end
  end

  // ---------------- stage 3: products ----------------
  logic                    s3_valid_r;
  logic [IDX_W-1:0]        s3_idx_r;
  logic [CNT_W-1:0]        s3_n_r;
  logic signed [DEV_W-1:0] s3_dev_r;
  logic [SQ_W-1:0]         s3_sq_r;
  logic [SMP_W-1:0]        s3_ref_r, s3_mn_r, s3_mx_r;
  logic                    s3_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (advance) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_idx_r <= s2_idx_r;
      s3_n_r   <= rep_n;
      s3_dev_r <= rep_dev;
      s3_sq_r  <= rep_sq;
      s3_ref_r <= rep_ref;
      s3_mn_r  <= rep_mn;
      s3_mx_r  <= rep_mx;
      s3_sat_r <= sat;
    end
  end

  localparam int unsigned REFN_W = SMP_W + CNT_W;
  localparam int unsigned A_W    = SQ_W + CNT_W;
  localparam int unsigned B_W    = 2*DEV_W;

  logic [DEV_W-1:0] dev_mag;

  assign dev_mag = s3_dev_r[DEV_W-1] ? DEV_W'(-s3_dev_r) : DEV_W'(s3_dev_r);

  // ---------------- stage 4: sums ----------------
  logic                    s4_valid_r;
  logic [IDX_W-1:0]        s4_idx_r;
  logic [CNT_W-1:0]        s4_n_r;
  logic signed [DEV_W-1:0] s4_dev_r;
  logic [REFN_W-1:0]       s4_refn_r;
  logic [A_W-1:0]          s4_a_r;
  logic [B_W-1:0]          s4_b_r;
  logic [VDEN_W-1:0]       s4_nn_r;
  logic [SMP_W-1:0]        s4_mn_r, s4_mx_r;
  logic                    s4_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (advance) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_idx_r  <= s3_idx_r;
      s4_n_r    <= s3_n_r;
      s4_dev_r  <= s3_dev_r;
      s4_refn_r <= REFN_W'(s3_ref_r) * REFN_W'(s3_n_r);
      s4_a_r    <= A_W'(s3_sq_r) * A_W'(s3_n_r);
      s4_b_r    <= B_W'(dev_mag) * B_W'(dev_mag);
      s4_nn_r   <= VDEN_W'(s3_n_r) * VDEN_W'(s3_n_r);
      s4_mn_r   <= s3_mn_r;
      s4_mx_r   <= s3_mx_r;
      s4_sat_r  <= s3_sat_r;
    end
  end

  localparam int unsigned TOT_W = REFN_W + 2;

  logic signed [TOT_W-1:0] total;
  logic [SUM_W-1:0]        tsum;
  logic [DIFF_W-1:0]       vdiff;

  always_comb begin
    total = $signed({2'b00, s4_refn_r}) + TOT_W'(s4_dev_r);
    tsum  = total[TOT_W-1] ? '0 : SUM_W'(total);
    vdiff = (B_W'(s4_a_r) > s4_b_r) ? DIFF_W'(B_W'(s4_a_r) - s4_b_r) : '0;
  end

  // ---------------- stage 5: numerators ----------------
  logic              s5_valid_r;
  logic [IDX_W-1:0]  s5_idx_r;
  logic [CNT_W-1:0]  s5_n_r;
  logic [SUM_W-1:0]  s5_t_r;
  logic [DIFF_W-1:0] s5_diff_r;
  logic [VDEN_W-1:0] s5_nn_r;
  logic [SMP_W-1:0]  s5_mn_r, s5_mx_r;
  logic              s5_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (advance) begin
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s5_idx_r  <= s4_idx_r;
      s5_n_r    <= s4_n_r;
      s5_t_r    <= tsum;
      s5_diff_r <= vdiff;
      s5_nn_r   <= s4_nn_r;
      s5_mn_r   <= s4_mn_r;
      s5_mx_r   <= s4_mx_r;
      s5_sat_r  <= s4_sat_r;
    end
  end

  // variance numerator is 16*(n*sq - dev^2) over n^2; anything at or past
  // 2^18 times the divisor saturates
  logic [VNUM_W-1:0] vnum;
  logic              vsat;
  div_in_t           ops;
  side_t             side;

  always_comb begin
    vnum      = {s5_diff_r, 4'b0000};
    vsat      = vnum >= VNUM_W'({s5_nn_r, {QUO_W{1'b0}}});
    ops.mden  = s5_n_r;
    ops.mrem  = '0;
    ops.mlo   = s5_t_r;
    ops.vden  = s5_nn_r;
    ops.vrem  = vnum[QUO_W+VDEN_W-1:QUO_W];
    ops.vlo   = vnum[QUO_W-1:0];
    side.idx  = s5_idx_r;
    side.n    = s5_n_r;
    side.mn   = s5_mn_r;
    side.mx   = s5_mx_r;
    side.sat  = s5_sat_r;
    side.vsat = vsat;
  end

  // ---------------- stage 6: divider operands ----------------
  logic    s6_valid_r;
  div_in_t s6_ops_r;
  side_t   s6_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r <= 1'b0;
    end else if (advance) begin
      s6_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s6_ops_r  <= ops;
      s6_side_r <= side;
    end
  end

  // ---------------- divider ----------------
  logic              dv_valid;
  div_out_t          dv_res;
  logic [SIDE_W-1:0] dv_side_raw;
  side_t             dv_side;

  mpss_div_pipe #(
    .PW (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (advance),
    .in_valid  (s6_valid_r),
    .in_ops    (s6_ops_r),
    .in_side   (s6_side_r),
    .out_valid (dv_valid),
    .out_res   (dv_res),
    .out_side  (dv_side_raw)
  );

  assign dv_side = side_t'(dv_side_raw);

  // ---------------- rounding and output register ----------------
  logic             zero_n;
  logic [MDEN_W:0]  rem2;
  logic             round_up;
  logic [QUO_W:0]   mq;
  logic [SMP_W-1:0] mean_nxt;
  logic [VAR_W-1:0] var_nxt;

  always_comb begin
    zero_n   = dv_side.n == '0;
    rem2     = {dv_res.mrem, 1'b0};
    // round half to even
    round_up = (rem2 > {1'b0, dv_side.n}) ||
               ((rem2 == {1'b0, dv_side.n}) && dv_res.mquo[0]);
    mq       = {1'b0, dv_res.mquo} + (QUO_W+1)'(round_up);
    if (zero_n) begin
      mean_nxt = '0;
      var_nxt  = '0;
    end else begin
      mean_nxt = (mq > (QUO_W+1)'(SAMPLE_MASK)) ? SAMPLE_MASK : mq[SMP_W-1:0];
      var_nxt  = dv_side.vsat ? '1 : dv_res.vquo;
    end
  end

  logic [IDX_W-1:0] out_idx_r;
  logic [SMP_W-1:0] out_mean_r, out_mn_r, out_mx_r;
  logic [VAR_W-1:0] out_var_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_idx_r  <= dv_side.idx;
      out_mean_r <= en_mv_r ? mean_nxt : '0;
      out_var_r  <= en_mv_r ? var_nxt : '0;
      out_cnt_r  <= en_mv_r ? dv_side.n : '0;
      out_sat_r  <= en_mv_r && dv_side.sat;
      out_mn_r   <= en_mn_r ? dv_side.mn : '0;
      out_mx_r   <= en_mx_r ? dv_side.mx : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_sat_r, out_cnt_r, out_mx_r, out_mn_r,
                       out_var_r, out_mean_r, out_idx_r};

`ifndef SYNTHESIS
  // the bypass only ever serves a row that stage 2 holds
  a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> s2_valid_r)
    else $error("bypass hit without an item in the update stage");

  // the store never sees an item write while it is being cleared
  a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !s2_wr && !s1_valid_r)
    else $error("item in flight during the clearing pass");

  // the clearing pass ends only on the last row
  a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_busy_r) |-> $past(clr_addr_r) == LAST_ADDR)
    else $error("clearing pass ended early");

  // the count stays within its limit
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_cnt_r <= CNT_FULL)
    else $error("sample count above the limit");

  // a dropped sample is reported only at the full count
  a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sat_r |-> out_cnt_r == CNT_FULL)
    else $error("saturation flag below the full count");
`endif

endmodule

@@ src/mpss_div_pipe.sv @@
`timescale 1ns / 1ps

module mpss_div_pipe
  import mpss_pkg::*;
#(
  parameter int unsigned PW = SIDE_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_valid,
  input  div_in_t        in_ops,
  input  logic [PW-1:0]  in_side,
  output logic           out_valid,
  output div_out_t       out_res,
  output logic [PW-1:0]  out_side
);

  logic              valid_r [QUO_W];
  logic [MDEN_W-1:0] mden_r  [QUO_W];
  logic [MDEN_W-1:0] mrem_r  [QUO_W];
  logic [QUO_W-1:0]  mlo_r   [QUO_W];
  logic [VDEN_W-1:0] vden_r  [QUO_W];
  logic [VDEN_W-1:0] vrem_r  [QUO_W];
  logic [QUO_W-1:0]  vlo_r   [QUO_W];
  logic [PW-1:0]     side_r  [QUO_W];

  // one quotient bit per stage for each lane
  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic              v_in;
    logic [MDEN_W-1:0] md_in, mr_in;
    logic [QUO_W-1:0]  ml_in;
    logic [VDEN_W-1:0] vd_in, vr_in;
    logic [QUO_W-1:0]  vl_in;
    logic [PW-1:0]     sd_in;
    logic [MDEN_W:0]   m_trial;
    logic [VDEN_W:0]   v_trial;
    logic              m_ge, v_ge;
    logic [MDEN_W-1:0] mrem_nxt;
    logic [VDEN_W-1:0] vrem_nxt;

    if (i == 0) begin : g_first
      assign v_in  = in_valid;
      assign md_in = in_ops.mden;
      assign mr_in = in_ops.mrem;
      assign ml_in = in_ops.mlo;
      assign vd_in = in_ops.vden;
      assign vr_in = in_ops.vrem;
      assign vl_in = in_ops.vlo;
      assign sd_in = in_side;
    end else begin : g_next
      assign v_in  = valid_r[i-1];
      assign md_in = mden_r[i-1];
      assign mr_in = mrem_r[i-1];
      assign ml_in = mlo_r[i-1];
      assign vd_in = vden_r[i-1];
      assign vr_in = vrem_r[i-1];
      assign vl_in = vlo_r[i-1];
      assign sd_in = side_r[i-1];
    end

    always_comb begin
      m_trial  = {mr_in, ml_in[QUO_W-1]};
      m_ge     = m_trial >= {1'b0, md_in};
      mrem_nxt = m_ge ? MDEN_W'(m_trial - {1'b0, md_in}) : m_trial[MDEN_W-1:0];
      v_trial  = {vr_in, vl_in[QUO_W-1]};
      v_ge     = v_trial >= {1'b0, vd_in};
      vrem_nxt = v_ge ? VDEN_W'(v_trial - {1'b0, vd_in}) : v_trial[VDEN_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (adv) begin
        valid_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        mden_r[i] <= md_in;
        mrem_r[i] <= mrem_nxt;
        mlo_r[i]  <= {ml_in[QUO_W-2:0], m_ge};
        vden_r[i] <= vd_in;
        vrem_r[i] <= vrem_nxt;
        vlo_r[i]  <= {vl_in[QUO_W-2:0], v_ge};
        side_r[i] <= sd_in;
      end
    end
  end

  assign out_valid    = valid_r[QUO_W-1];
  assign out_res.mquo = mlo_r[QUO_W-1];
  assign out_res.mrem = mrem_r[QUO_W-1];
  assign out_res.vquo = vlo_r[QUO_W-1];
  assign out_side     = side_r[QUO_W-1];

endmodule

@@ tb/masked_pixel_stack_statistics_test.sv @@
`timescale 1ns / 1ps

module masked_pixel_stack_statistics_test;
  import mpss_pkg::*;

  // one pixel sample as it goes into the block
  typedef struct {
    logic [15:0] pix;
    logic [7:0]  smp;
    logic        inc;
  } pixel_item_t;

  // statistics the block reports for one pixel
  typedef struct {
    logic [15:0] pix;
    logic [7:0]  mean;
    logic [17:0] var16;
    logic [7:0]  mn;
    logic [7:0]  mx;
    logic [10:0] cnt;
    logic        sat;
  } pixel_stats_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  masked_pixel_stack_statistics i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow copy of the per-pixel store and the enables
  bit          known_q [65536];
  logic [7:0]  refv_q  [65536];
  int unsigned cnt_q   [65536];
  longint      dev_q   [65536];
  longint      sq_q    [65536];
  logic [7:0]  min_q   [65536];
  logic [7:0]  max_q   [65536];
  bit en_mean_var = 1'b1;
  bit en_min = 1'b1;
  bit en_max = 1'b1;

  pixel_item_t  pending_q [$];   // items waiting to be offered
  pixel_stats_t stats_q   [$];   // statistics still to come out
  pixel_item_t  cur_item;
  int  fail_cnt = 0;
  bit  idle_on = 1'b1;          // both sides insert random gaps when set
  bit  long_hold_req = 1'b0;    // asks the receiver for one long stall
  int  in_gap = 0;
  int  out_wait = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  task automatic report(input string what, input logic [71:0] got, input logic [71:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    fail_cnt++;
  endtask

  // rounded mean, ties to even, clamped to the sample range
  function automatic logic [7:0] mean_calc(int unsigned n, longint dev, logic [7:0] r);
    longint total, q, rm;
    if (n == 0) return 8'd0;
    total = dev + longint'(r) * n;
    if (total < 0) total = 0;
    q = total / n;
    rm = total % n;
    if (2 * rm > n || (2 * rm == n && q[0])) q++;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  // population variance scaled by 16, truncated, saturated at the 18-bit maximum
  function automatic logic [17:0] var_calc(int unsigned n, longint dev, longint sq);
    longint mag, a, b, v;
    if (n == 0) return 18'd0;
    mag = dev < 0 ? -dev : dev;
    a = sq * n;
    b = mag * mag;
    if (a <= b) return 18'd0;
    v = ((a - b) * 16) / (longint'(n) * n);
    if (v > 262143) v = 262143;
    return v[17:0];
  endfunction

  // update the shadow store for one accepted sample and queue what comes out
  task automatic update_pixel(input pixel_item_t it);
    pixel_stats_t st;
    int unsigned p;
    longint d;
    bit sat;
    p = it.pix;
    sat = 1'b0;
    if (en_mean_var && it.inc) begin
      if (cnt_q[p] >= MAX_IMAGES) begin
        sat = 1'b1;
      end else begin
        if (!known_q[p]) begin
          refv_q[p] = it.smp;
          known_q[p] = 1'b1;
        end
        d = longint'(it.smp) - longint'(refv_q[p]);
        cnt_q[p]++;
        dev_q[p] += d;
        sq_q[p] += d * d;
      end
    end
    if (en_min && it.inc && it.smp < min_q[p]) min_q[p] = it.smp;
    if (en_max && it.inc && it.smp > max_q[p]) max_q[p] = it.smp;
    st.pix = it.pix;
    if (en_mean_var) begin
      st.mean = mean_calc(cnt_q[p], dev_q[p], known_q[p] ? refv_q[p] : 8'd0);
      st.var16 = var_calc(cnt_q[p], dev_q[p], sq_q[p]);
      st.cnt = cnt_q[p][10:0];
      st.sat = sat;
    end else begin
      st.mean = '0;
      st.var16 = '0;
      st.cnt = '0;
      st.sat = 1'b0;
    end
    st.mn = en_min ? min_q[p] : 8'd0;
    st.mx = en_max ? max_q[p] : 8'd0;
    stats_q.push_back(st);
  endtask

  // sender: waits a random gap after each transaction when idle_on is set, holds data while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) update_pixel(cur_item);
      if (!in_tvalid || in_tready) begin
        if (in_gap != 0) begin
          in_tvalid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (pending_q.size() != 0) begin
          cur_item = pending_q.pop_front();
          in_tdata <= {cur_item.smp, cur_item.pix};
          in_tuser <= cur_item.inc;
          in_tvalid <= 1'b1;
          in_gap <= idle_on ? $urandom_range(0, 9) : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result transaction, stalls at random when idle_on is set and once for long
  always @(posedge clk) begin
    pixel_stats_t want;
    int w;
    if (rst_n && out_tvalid && out_tready) begin
      if (stats_q.size() == 0) begin
        report("unexpected result", out_tdata, '0);
      end else begin
        want = stats_q.pop_front();
        if (out_tdata[15:0] != want.pix) report("out_index", out_tdata[15:0], want.pix);
        if (out_tdata[23:16] != want.mean) report("mean_value", out_tdata[23:16], want.mean);
        if (out_tdata[41:24] != want.var16)
          report("variance_value", out_tdata[41:24], want.var16);
        if (out_tdata[49:42] != want.mn) report("minimum_value", out_tdata[49:42], want.mn);
        if (out_tdata[57:50] != want.mx) report("maximum_value", out_tdata[57:50], want.mx);
        if (out_tdata[68:58] != want.cnt) report("sample_count", out_tdata[68:58], want.cnt);
        if (out_tdata[69] != want.sat) report("count_saturated", out_tdata[69], want.sat);
      end
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (long_hold_req && !hold_done) begin
      // long stall so the pipeline fills and input backs up
      hold_done <= 1'b1;
      hold_left <= 300;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      w = idle_on ? $urandom_range(0, 9) : 0;
      out_tready <= (w == 0);
      out_wait <= (w == 0) ? 0 : w - 1;
    end else if (out_wait != 0) begin
      out_wait <= out_wait - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // register write: a setup phase, then an access phase with penable high
  task automatic reg_write(input logic [1:0] idx, input bit val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= CFG_AW'(idx) << 2;
    cfg_pwdata <= {31'($urandom) << 1, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_MEAN_VAR: en_mean_var = val;
      REG_MINIMUM:  en_min = val;
      REG_MAXIMUM:  en_max = val;
      default: ;
    endcase
  endtask

  task automatic set_enables(input bit mv, input bit mn, input bit mx);
    reg_write(REG_MEAN_VAR, mv);
    reg_write(REG_MINIMUM, mn);
    reg_write(REG_MAXIMUM, mx);
  endtask

  // block until every result is back, plus the pipeline depth
  // (looks just after each edge so sender and receiver have settled)
  task automatic drain();
    while (pending_q.size() != 0 || in_tvalid || stats_q.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (30) @(posedge clk);
  endtask

  task automatic push_pixel(input logic [15:0] p, input logic [7:0] s, input bit inc);
    pixel_item_t it;
    it.pix = p;
    it.smp = s;
    it.inc = inc;
    pending_q.push_back(it);
  endtask

  // mostly a small working set so stats build up; sometimes any index
  task automatic push_random(input int count);
    logic [15:0] p;
    logic [7:0] s;
    repeat (count) begin
      p = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'(16'h0100 + $urandom_range(0, 15));
      case ($urandom_range(0, 5))
        0: s = 8'd0;
        1: s = 8'd255;
        default: s = 8'($urandom);
      endcase
      push_pixel(p, s, $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    for (int i = 0; i < 65536; i++) begin
      known_q[i] = 1'b0;
      refv_q[i] = '0;
      cnt_q[i] = 0;
      dev_q[i] = 0;
      sq_q[i] = 0;
      min_q[i] = 8'hff;
      max_q[i] = 8'h00;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty pixel, excluded first sample, extremes, top index, bit patterns
    push_pixel(16'd0, 8'd77, 1'b0);
    push_pixel(16'd0, 8'd0, 1'b1);
    push_pixel(16'd0, 8'd255, 1'b1);
    push_pixel(16'd0, 8'd128, 1'b1);
    push_pixel(16'd0, 8'd1, 1'b0);
    push_pixel(16'hffff, 8'd255, 1'b1);
    push_pixel(16'hffff, 8'd0, 1'b1);
    push_pixel(16'hffff, 8'd3, 1'b0);
    push_pixel(16'haaaa, 8'haa, 1'b1);
    push_pixel(16'h5555, 8'h55, 1'b1);
    push_pixel(16'haaaa, 8'h55, 1'b1);
    push_pixel(16'h5555, 8'haa, 1'b1);
    push_pixel(16'd2, 8'd10, 1'b1);
    push_pixel(16'd2, 8'd11, 1'b1);
    push_pixel(16'd2, 8'd12, 1'b1);
    push_pixel(16'd2, 8'd13, 1'b1);
    drain();

    // fill one pixel past its full count, with a long receiver stall on the way
    for (int k = 0; k < 1050; k++) begin
      push_pixel(16'd7, 8'($urandom), k % 50 != 3);
      if (k == 200) long_hold_req = 1'b1;
    end
    drain();

    push_random(180);
    drain();
    set_enables(1'b0, 1'b1, 1'b0);
    push_random(120);
    push_pixel(16'd7, 8'd0, 1'b1);
    drain();
    set_enables(1'b1, 1'b0, 1'b1);
    push_random(120);
    push_pixel(16'd7, 8'd255, 1'b1);
    drain();
    set_enables(1'b0, 1'b0, 1'b0);
    push_random(100);
    drain();
    // unknown register must leave the enables alone
    set_enables(1'b1, 1'b1, 1'b1);
    reg_write(2'd3, 1'b0);
    idle_on = 1'b0;
    push_random(120);
    drain();
    idle_on = 1'b1;
    push_random(150);
    drain();

    if (fail_cnt == 0) begin
      $display("masked_pixel_stack_statistics verification clean");
    end else begin
      $display("masked_pixel_stack_statistics verification failed");
    end
    $finish;
  end

  // covers the post-reset clearing pass plus the slowest legal traffic
  initial begin
    #5ms;
    $display("masked_pixel_stack_statistics verification failed");
    $finish;
  end

endmodule
